[design/deq_pkg.sv]
// deq_pkg: shared types, sizes and codes for the double-ended queue unit
// no dependencies; imported by deq_ctrl, deq_datapath, double_ended_queue_unit, deq_checker and testbench

package deq_pkg;

    localparam int DEPTH      = 1024;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // fixed field widths of the request and response
    localparam int CMD_W   = 3;
    localparam int VALUE_W = 32;
    localparam int OCC_W   = 11;
    localparam int STAT_W  = 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd4;
    localparam logic [CMD_W-1:0] CMD_QUERY      = 3'd5;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_UNDERFLOW = 2'd1;
    localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 2'd2;

    typedef logic [ADDR_W-1:0]     addr_t;
    typedef logic [CNT_W-1:0]      count_t;
    typedef logic [DATA_WIDTH-1:0] word_t;

    typedef struct packed {
        logic [CMD_W-1:0]          command;
        logic signed [VALUE_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] front_value;
        logic signed [VALUE_W-1:0] back_value;
        logic [OCC_W-1:0]          occupancy;
        logic                      is_empty;
        logic [STAT_W-1:0]         status;
    } rsp_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_RESP
    } state_t;

    // controller to datapath strobes
    typedef struct packed {
        logic load;
        logic exec;
        logic read;
    } ctrl_t;

    function automatic addr_t ring_next(input addr_t i);
        return (i == addr_t'(DEPTH - 1)) ? '0 : addr_t'(i + addr_t'(1));
    endfunction

    function automatic addr_t ring_prev(input addr_t i);
        return (i == '0) ? addr_t'(DEPTH - 1) : addr_t'(i - addr_t'(1));
    endfunction

    // stored word to a 32-bit response field, zero extended or truncated
    function automatic logic [VALUE_W-1:0] word_to_field(input word_t w);
        logic [63:0] wide;
        wide = 64'(w);
        return wide[VALUE_W-1:0];
    endfunction

endpackage

[design/double_ended_queue_unit.sv]
// double_ended_queue_unit: top level of the double-ended queue on a ring store
// depends on deq_pkg, deq_ctrl and deq_datapath
//
// usage
//   request channel: cmd_valid / cmd_stall / cmd carries a command and a value;
//   a request is taken at a rising edge with cmd_valid high and cmd_stall low
//   response channel: rsp_valid / rsp_stall / rsp carries front value, back
//   value, occupancy, empty flag and status, exactly one response per request
//   commands: push back, push front, pop back, pop front, clear, query;
//   pops and queries of an empty queue report underflow and change nothing,
//   pushes into a full queue report overflow and change nothing
// timing
//   the unit handles one request at a time: take (idle), pointer update and store
//   write (execute), two-port store read (read), response shown (respond)
//   rsp_valid rises once the execute and read states have passed; no new
//   request is taken until the response is delivered and the sequencer has
//   returned to idle, the state that takes the request; the ring store read
//   is registered after each update
// reset
//   rst_n clears head, tail and count to zero and returns the sequencer to
//   idle; the store contents are not cleared and are never reported unwritten
// stall
//   while rsp_stall is high the response holds steady and cmd_stall stays
//   high, so no new request is taken until the response is delivered

module double_ended_queue_unit
    import deq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_stall,
    input  req_t cmd,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    ctrl_t ctrl;

    // sequencer: idle -> execute -> read -> respond
    deq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .ctrl      (ctrl)
    );

    // pointers, count, ring store and response registers
    deq_datapath u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .cmd   (cmd),
        .rsp   (rsp)
    );

    // one request in flight: after taking a request no other is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall) |=> cmd_stall)
        else $error("request taken while another is in flight");

    // occupancy never passes the store depth
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.occupancy <= OCC_W'(DEPTH)))
        else $error("occupancy above depth");

    // empty flag agrees with occupancy, and an empty queue shows zero values
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ((rsp.is_empty == (rsp.occupancy == '0)) &&
                       (!rsp.is_empty || (rsp.front_value == '0 && rsp.back_value == '0))))
        else $error("empty flag or empty values inconsistent");

    // overflow only when full, underflow only when empty
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ((rsp.status != STAT_OVERFLOW || rsp.occupancy == OCC_W'(DEPTH)) &&
                       (rsp.status != STAT_UNDERFLOW || rsp.is_empty)))
        else $error("status does not match occupancy");

endmodule

[design/deq_ctrl.sv]
// deq_ctrl: sequencing state machine of the double-ended queue unit
// depends on deq_pkg

module deq_ctrl
    import deq_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  cmd_valid,
    output logic  cmd_stall,
    output logic  rsp_valid,
    input  logic  rsp_stall,
    output ctrl_t ctrl
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        cmd_stall  = 1'b1;
        rsp_valid  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                cmd_stall = 1'b0;
                if (cmd_valid)
                begin
                    ctrl.load  = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                ctrl.exec  = 1'b1;
                state_next = S_READ;
            end
            S_READ:
            begin
                ctrl.read  = 1'b1;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                rsp_valid = 1'b1;
                if (!rsp_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[design/deq_datapath.sv]
// deq_datapath: ring store, head/tail pointers, count and response registers
// depends on deq_pkg

module deq_datapath
    import deq_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  ctrl_t ctrl,
    input  req_t  cmd,
    output rsp_t  rsp
);

    logic [CMD_W-1:0]  cmd_reg;
    word_t             val_reg;
    addr_t             head_reg;
    addr_t             head_next;
    addr_t             tail_reg;
    addr_t             tail_next;
    count_t            count_reg;
    count_t            count_next;
    logic [STAT_W-1:0] status_reg;
    logic [STAT_W-1:0] status_next;
    logic              mem_we;
    addr_t             mem_waddr;
    logic              full;
    logic              empty;
    word_t             rd_front_reg;
    word_t             rd_back_reg;

    word_t store [DEPTH];

    assign full  = (count_reg == count_t'(DEPTH));
    assign empty = (count_reg == '0);

    // request capture
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg <= cmd.command;
            val_reg <= DATA_WIDTH'($unsigned(cmd.value));
        end
    end

    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        status_next = STAT_OK;
        mem_we      = 1'b0;
        mem_waddr   = tail_reg;
        case (cmd_reg)
            CMD_PUSH_BACK:
            begin
                if (full)
                begin
                    status_next = STAT_OVERFLOW;
                end
                else
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = tail_reg;
                    tail_next  = ring_next(tail_reg);
                    count_next = count_t'(count_reg + count_t'(1));
                end
            end
            CMD_PUSH_FRONT:
            begin
                if (full)
                begin
                    status_next = STAT_OVERFLOW;
                end
                else
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = ring_prev(head_reg);
                    head_next  = ring_prev(head_reg);
                    count_next = count_t'(count_reg + count_t'(1));
                end
            end
            CMD_POP_BACK:
            begin
                if (empty)
                begin
                    status_next = STAT_UNDERFLOW;
                end
                else
                begin
                    tail_next  = ring_prev(tail_reg);
                    count_next = count_t'(count_reg - count_t'(1));
                end
            end
            CMD_POP_FRONT:
            begin
                if (empty)
                begin
                    status_next = STAT_UNDERFLOW;
                end
                else
                begin
                    head_next  = ring_next(head_reg);
                    count_next = count_t'(count_reg - count_t'(1));
                end
            end
            CMD_CLEAR:
            begin
                head_next  = '0;
                tail_next  = '0;
                count_next = '0;
            end
            CMD_QUERY:
            begin
                if (empty)
                begin
                    status_next = STAT_UNDERFLOW;
                end
            end
            default:
            begin
                status_next = STAT_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            tail_reg   <= '0;
            count_reg  <= '0;
            status_reg <= STAT_OK;
        end
        else if (ctrl.exec)
        begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            status_reg <= status_next;
        end
    end

    // ring store: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (ctrl.exec && mem_we)
        begin
            store[mem_waddr] <= val_reg;
        end
        if (ctrl.read)
        begin
            rd_front_reg <= store[head_reg];
            rd_back_reg  <= store[ring_prev(tail_reg)];
        end
    end

    always_comb
    begin
        rsp.front_value = empty ? '0 : word_to_field(rd_front_reg);
        rsp.back_value  = empty ? '0 : word_to_field(rd_back_reg);
        rsp.occupancy   = OCC_W'(count_reg);
        rsp.is_empty    = empty;
        rsp.status      = status_reg;
    end

endmodule

[sim/deq_checker.sv]
// deq_checker: watches both channels of the double-ended queue unit and checks each response
// keeps its own ring-store copy of the deque and queues one expected view per request
// depends on deq_pkg

module deq_checker
    import deq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    input  logic cmd_stall,
    input  req_t cmd,
    input  logic rsp_valid,
    input  logic rsp_stall,
    input  rsp_t rsp,
    output int   errors,
    output int   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // slots for expected views waiting on their response
    localparam int unsigned VIEW_SLOTS = 16;

    logic [VALUE_W-1:0] ring_words [DEPTH];
    int unsigned        head_slot;
    int unsigned        tail_slot;
    int unsigned        held;
    rsp_t               pending_views [VIEW_SLOTS];
    int unsigned        view_wr;
    int unsigned        view_rd;
    int unsigned        views_checked;

    initial
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            ring_words[i] = '0;
        end
        head_slot     = 0;
        tail_slot     = 0;
        held          = 0;
        view_wr       = 0;
        view_rd       = 0;
        views_checked = 0;
    end

    task automatic flag_mismatch(input string what);
        errors++;
        $display("[%0t] deq mismatch on response %0d: %s", $realtime, views_checked, what);
    endtask

    // applies one request to the local deque, returns the view it should report
    function automatic rsp_t next_view(input req_t r);
        rsp_t               v;
        logic [VALUE_W-1:0] word;
        v        = '0;
        v.status = STAT_OK;
        word     = VALUE_W'(word_t'(r.value));
        case (r.command)
            CMD_PUSH_BACK:
            begin
                if (held >= DEPTH)
                begin
                    v.status = STAT_OVERFLOW;
                end
                else
                begin
                    ring_words[tail_slot] = word;
                    tail_slot = (tail_slot + 1) % DEPTH;
                    held++;
                end
            end
            CMD_PUSH_FRONT:
            begin
                if (held >= DEPTH)
                begin
                    v.status = STAT_OVERFLOW;
                end
                else
                begin
                    head_slot = (head_slot + DEPTH - 1) % DEPTH;
                    ring_words[head_slot] = word;
                    held++;
                end
            end
            CMD_POP_BACK:
            begin
                if (held == 0)
                begin
                    v.status = STAT_UNDERFLOW;
                end
                else
                begin
                    tail_slot = (tail_slot + DEPTH - 1) % DEPTH;
                    held--;
                end
            end
            CMD_POP_FRONT:
            begin
                if (held == 0)
                begin
                    v.status = STAT_UNDERFLOW;
                end
                else
                begin
                    head_slot = (head_slot + 1) % DEPTH;
                    held--;
                end
            end
            CMD_CLEAR:
            begin
                head_slot = 0;
                tail_slot = 0;
                held      = 0;
            end
            CMD_QUERY:
            begin
                if (held == 0)
                begin
                    v.status = STAT_UNDERFLOW;
                end
            end
            default:
            begin
            end
        endcase
        if (held != 0)
        begin
            v.front_value = ring_words[head_slot];
            v.back_value  = ring_words[(tail_slot + DEPTH - 1) % DEPTH];
        end
        v.occupancy = OCC_W'(held);
        v.is_empty  = (held == 0);
        return v;
    endfunction

    task automatic compare_view(input rsp_t got, input rsp_t want);
        if (got.front_value !== want.front_value)
        begin
            flag_mismatch($sformatf("front_value %0d, expected %0d",
                                    got.front_value, want.front_value));
        end
        if (got.back_value !== want.back_value)
        begin
            flag_mismatch($sformatf("back_value %0d, expected %0d",
                                    got.back_value, want.back_value));
        end
        if (got.occupancy !== want.occupancy)
        begin
            flag_mismatch($sformatf("occupancy %0d, expected %0d",
                                    got.occupancy, want.occupancy));
        end
        if (got.is_empty !== want.is_empty)
        begin
            flag_mismatch($sformatf("is_empty %b, expected %b", got.is_empty, want.is_empty));
        end
        if (got.status !== want.status)
        begin
            flag_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // responses first: one delivered at this edge belongs to an older request
            if (rsp_valid && !rsp_stall)
            begin
                if (view_wr == view_rd)
                begin
                    flag_mismatch("response with no request outstanding");
                end
                else
                begin
                    compare_view(rsp, pending_views[view_rd % VIEW_SLOTS]);
                    view_rd++;
                end
                views_checked++;
            end
            if (cmd_valid && !cmd_stall)
            begin
                if (view_wr - view_rd >= VIEW_SLOTS)
                begin
                    flag_mismatch("too many requests outstanding");
                end
                else
                begin
                    pending_views[view_wr % VIEW_SLOTS] = next_view(cmd);
                    view_wr++;
                end
            end
        end
        outstanding <= int'(view_wr - view_rd);
    end

endmodule

[sim/testbench.sv]
// testbench: stimulus and verdict for the double-ended queue unit
// drives requests and response stalls, the checker beside the unit does the comparing
// depends on deq_pkg, deq_checker and double_ended_queue_unit

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import deq_pkg::*;

    // command codes the unit decodes as no-ops
    localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    localparam int RANDOM_REQUESTS = 620;
    // slowest run is well under 100 us, this is many times that
    localparam int RUN_LIMIT_NS    = 2_000_000;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic cmd_valid = 1'b0;
    req_t cmd       = '0;
    logic rsp_stall = 1'b0;
    logic cmd_stall;
    logic rsp_valid;
    rsp_t rsp;

    int errors;
    int outstanding;

    // chance per cycle, in percent, that the request side holds off or the response side stalls
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    // random requests still to send in the current phase
    int random_left;

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    double_ended_queue_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    deq_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .cmd         (cmd),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .errors      (errors),
        .outstanding (outstanding)
    );

    // response side: a fresh stall draw every cycle
    always @(posedge clk)
    begin
        rsp_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // offer one request, maybe after some idle cycles, and return at the edge that takes it
    task automatic send_request(input logic [CMD_W-1:0] code,
                                input logic signed [VALUE_W-1:0] data);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= '{command: code, value: data};
        // payload holds steady while stalled
        @(posedge clk);
        while (cmd_stall)
        begin
            @(posedge clk);
        end
    endtask

    // mostly random words, with the extremes mixed in often
    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(9))
            0:       return {1'b1, {(VALUE_W-1){1'b0}}};
            1:       return {1'b0, {(VALUE_W-1){1'b1}}};
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // a run of requests leaning toward pushes, toward pops, or neither
    // pop-leaning runs drain the deque and then hit underflow
    task automatic random_burst();
        int               len;
        int               push_share;
        int               roll;
        logic [CMD_W-1:0] code;
        len = $urandom_range(40, 8);
        case ($urandom_range(2))
            0:       push_share = 75;
            1:       push_share = 25;
            default: push_share = 50;
        endcase
        for (int n = 0; n < len && random_left > 0; n++)
        begin
            roll = $urandom_range(99);
            if (roll < 2)
            begin
                code = CMD_CLEAR;
            end
            else if (roll < 4)
            begin
                code = $urandom_range(1) ? CMD_SPARE_6 : CMD_SPARE_7;
            end
            else if (roll < 12)
            begin
                code = CMD_QUERY;
            end
            else if ($urandom_range(99) < push_share)
            begin
                code = $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
            end
            else
            begin
                code = $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
            end
            send_request(code, pick_value());
            // no-op codes do not count toward the random total
            if (code != CMD_SPARE_6 && code != CMD_SPARE_7)
            begin
                random_left--;
            end
        end
    endtask

    initial
    begin
        // reset held low from the start, released on an edge
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty deque reads
        send_request(CMD_QUERY, {1'b0, {(VALUE_W-1){1'b1}}});
        send_request(CMD_POP_BACK, '1);
        send_request(CMD_POP_FRONT, '0);
        // pushes of the extremes at both ends, front push wraps the head below slot 0
        send_request(CMD_PUSH_BACK, {1'b1, {(VALUE_W-1){1'b0}}});
        send_request(CMD_PUSH_FRONT, {1'b0, {(VALUE_W-1){1'b1}}});
        send_request(CMD_PUSH_BACK, '1);
        send_request(CMD_PUSH_FRONT, '0);
        send_request(CMD_QUERY, 32'sh5A5A_A5A5);
        // no-op codes leave everything alone
        send_request(CMD_SPARE_6, 32'sh1234_5678);
        send_request(CMD_SPARE_7, '1);
        // pops at both ends down to empty, value ignored
        send_request(CMD_POP_BACK, 32'sh0F0F_F0F0);
        send_request(CMD_POP_FRONT, 32'sh7777_7777);
        send_request(CMD_POP_FRONT, '1);
        send_request(CMD_POP_BACK, '0);
        send_request(CMD_POP_FRONT, 32'sd1);
        // clear with entries present, then reuse from slot 0
        send_request(CMD_PUSH_FRONT, 32'sd1);
        send_request(CMD_PUSH_BACK, 32'sd2);
        send_request(CMD_CLEAR, 32'sd3);
        send_request(CMD_QUERY, '0);
        send_request(CMD_PUSH_FRONT, -32'sd4);
        send_request(CMD_POP_BACK, '0);

        // random: sender idles 14 / receiver 61, then swapped, then no idling
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct  = 14;
                    recv_stall_pct = 61;
                end
                1:
                begin
                    send_idle_pct  = 61;
                    recv_stall_pct = 14;
                end
                default:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            random_left = RANDOM_REQUESTS / 3;
            while (random_left > 0)
            begin
                random_burst();
            end
        end

        cmd_valid <= 1'b0;
        recv_stall_pct = 0;

        // drain: wait for the last responses, bounded, then let the unit settle before the verdict
        @(posedge clk);
        for (int n = 0; n < 5000 && outstanding != 0; n++)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);

        if (errors == 0 && outstanding == 0)
        begin
            $display("double_ended_queue_unit regression: pass");
        end
        else
        begin
            $display("double_ended_queue_unit regression: fail");
        end
        $finish;
    end

    // watchdog for a hung handshake
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("timeout: request or response channel stuck");
        $display("double_ended_queue_unit regression: fail");
        $finish;
    end

endmodule
